/* hw/rtl/lgs_pkg.sv */
// shared types and constants for the life grid generation step block
package lgs_pkg;

    // action codes carried on the request channel
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    // neighbour counts of the b3/s23 rule
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // capture request payload
        logic rd_en;        // read one grid row
        logic sweep;        // read address comes from the sweep counter
        logic step_data;    // row data of the sweep is present
        logic cell_wr;      // write back the addressed row with one cell changed
        logic load_out;     // load the result register from the addressed row
        logic clear_all;    // mark every row dead
        logic clear_border; // mark the first and last rows dead
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;     // result register can take a new result
    } status_t;

endpackage

/* hw/rtl/life_grid_generation_step.sv */
// top level of the life grid generation step block
//
// channel   dir  tdata (low bit up)              tuser
// s_        in   row[5:0] column[11:6] live_in[12] action[1:0]
// m_        out  live_out[0]                     -
//
// clear acts on acceptance; write cell reads a row and writes it back;
// read cell reads a row and waits for the output register; advance reads every row,
// one row word per cycle, from the single-read, single-write grid memory.
// reset leaves all cells dead through per-row valid bits; no clearing pass.
// a read result waits in the output register while further requests run;
// a second read holds off new requests until that register frees.
module life_grid_generation_step #(
    parameter int GRID_SIZE = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // row, column, live_in, zero fill
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // live_out, zero fill
);
    import lgs_pkg::*;

    localparam int AW = $clog2(GRID_SIZE);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] sweep_addr;
    logic          out_live;

    // request sequencing
    lgs_controller #(
        .GRID_SIZE (GRID_SIZE),
        .AW        (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_action (action_t'(s_tuser)),
        .status     (status),
        .cmd        (cmd),
        .sweep_addr (sweep_addr)
    );

    // grid storage and rule logic
    lgs_datapath #(
        .GRID_SIZE (GRID_SIZE),
        .AW        (AW)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .sweep_addr (sweep_addr),
        .req_row    (s_tdata[5:0]),
        .req_column (s_tdata[11:6]),
        .req_live   (s_tdata[12]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_live   (out_live)
    );

    assign m_tdata = {7'd0, out_live};

endmodule

/* hw/rtl/lgs_datapath.sv */
// grid memory, row window, rule logic and result register
module lgs_datapath #(
    parameter int GRID_SIZE = 64,
    parameter int AW        = $clog2(GRID_SIZE)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  lgs_pkg::cmd_t   cmd,
    output lgs_pkg::status_t status,
    input  logic [AW-1:0]   sweep_addr,
    input  logic [5:0]      req_row,
    input  logic [5:0]      req_column,
    input  logic            req_live,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_live
);
    import lgs_pkg::*;

    logic [GRID_SIZE-1:0] mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] row_valid_reg;
    logic [GRID_SIZE-1:0] rd_q_reg;
    logic                 rd_v_reg;
    logic [AW-1:0]        rd_idx_reg;
    logic [GRID_SIZE-1:0] rd_row;
    logic [GRID_SIZE-1:0] top_reg;
    logic [GRID_SIZE-1:0] mid_reg;
    logic [GRID_SIZE-1:0] life_row;
    logic [AW-1:0]        row_idx_reg;
    logic [AW-1:0]        col_idx_reg;
    logic                 live_reg;
    logic                 inside_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        wr_addr;
    logic [GRID_SIZE-1:0] wr_data;
    logic                 step_we;
    logic                 out_valid_reg;
    logic                 out_live_reg;
    logic [GRID_SIZE-1:0] cell_row;

    // request payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            row_idx_reg <= AW'(req_row);
            col_idx_reg <= AW'(req_column);
            live_reg    <= req_live;
            inside_reg  <= (32'(req_row) < GRID_SIZE) && (32'(req_column) < GRID_SIZE);
        end
    end

    // row read port address
    assign rd_addr = cmd.sweep ? sweep_addr : row_idx_reg;

    // a row never written since the last clear reads as dead
    assign rd_row = rd_v_reg ? rd_q_reg : '0;

    // next generation of the middle row of the window
    always_comb begin
        logic [3:0] n;
        life_row = '0;
        for (int c = 1; c < GRID_SIZE - 1; c++) begin
            n = 4'(top_reg[c-1]) + 4'(top_reg[c]) + 4'(top_reg[c+1])
              + 4'(mid_reg[c-1]) + 4'(mid_reg[c+1])
              + 4'(rd_row[c-1])  + 4'(rd_row[c])  + 4'(rd_row[c+1]);
            life_row[c] = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && mid_reg[c]);
        end
    end

    // addressed row with one cell replaced
    always_comb begin
        cell_row = rd_row;
        cell_row[col_idx_reg] = live_reg;
    end

    // write port select
    assign step_we = cmd.step_data && (rd_idx_reg >= AW'(2));
    assign mem_we  = step_we || (cmd.cell_wr && inside_reg);
    assign wr_addr = step_we ? (rd_idx_reg - AW'(1)) : row_idx_reg;
    assign wr_data = step_we ? life_row : cell_row;

    // grid memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // read pipeline tags
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
        end else if (cmd.rd_en) begin
            rd_v_reg <= row_valid_reg[rd_addr];
        end
    end

    // per-row valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (cmd.clear_all) begin
            row_valid_reg <= '0;
        end else begin
            if (mem_we) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.clear_border) begin
                row_valid_reg[0]           <= 1'b0;
                row_valid_reg[GRID_SIZE-1] <= 1'b0;
            end
        end
    end

    // three-row window shift
    always_ff @(posedge aclk) begin
        if (cmd.step_data) begin
            top_reg <= mid_reg;
            mid_reg <= rd_row;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_live_reg <= inside_reg && rd_row[col_idx_reg];
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_live        = out_live_reg;

endmodule

/* hw/rtl/lgs_controller.sv */
// request sequencer and generation sweep counter
module lgs_controller #(
    parameter int GRID_SIZE = 64,
    parameter int AW        = $clog2(GRID_SIZE)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    output logic             req_ready,
    input  lgs_pkg::action_t req_action,
    input  lgs_pkg::status_t status,
    output lgs_pkg::cmd_t    cmd,
    output logic [AW-1:0]    sweep_addr
);
    import lgs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SWEEP   = 6'b000010,
        ST_DRAIN   = 6'b000100,
        ST_CELL_RD = 6'b001000,
        ST_CELL_WR = 6'b010000,
        ST_READ_RD = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] row_cnt_reg, row_cnt_next;
    logic          pend_out_reg, pend_out_next;

    assign req_ready  = (state_reg == ST_IDLE) && !pend_out_reg;
    assign sweep_addr = row_cnt_reg;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        pend_out_next = pend_out_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                // a read result waiting for the output register
                if (pend_out_reg) begin
                    if (status.out_free) begin
                        cmd.load_out  = 1'b1;
                        pend_out_next = 1'b0;
                    end
                end else if (req_valid) begin
                    cmd.accept = 1'b1;
                    case (req_action)
                        ACT_CLEAR: cmd.clear_all = 1'b1;
                        ACT_WRITE: state_next = ST_CELL_RD;
                        ACT_STEP: begin
                            row_cnt_next = '0;
                            state_next   = ST_SWEEP;
                        end
                        default: state_next = ST_READ_RD;
                    endcase
                end
            end
            ST_SWEEP: begin
                cmd.rd_en     = 1'b1;
                cmd.sweep     = 1'b1;
                cmd.step_data = (row_cnt_reg != '0);
                row_cnt_next  = row_cnt_reg + AW'(1);
                if (row_cnt_reg == AW'(GRID_SIZE - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.step_data    = 1'b1;
                cmd.clear_border = 1'b1;
                state_next       = ST_IDLE;
            end
            ST_CELL_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CELL_WR;
            end
            ST_CELL_WR: begin
                cmd.cell_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_READ_RD: begin
                cmd.rd_en     = 1'b1;
                pend_out_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_cnt_reg  <= '0;
            pend_out_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            pend_out_reg <= pend_out_next;
        end
    end

endmodule
